// ===== rtl/core/fndt_pkg.sv =====
package fndt_pkg;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	// response status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int HALF_W  = 64;
	localparam int INODE_W = 16;
	localparam int STAT_W  = 2;
	localparam int USED_W  = 5;
	localparam int IN_W    = 152;
	localparam int OUT_W   = 24;

endpackage

// ===== rtl/core/file_name_directory_table.sv =====
// Channel | dir | tdata fields, LSB first                        | handshake
// s_*     | in  | cmd[1:0] name_high[65:2] name_low[129:66]        | tvalid/tready
//         |     | inode_in[145:130], zero fill to 151              |
// m_*     | out | status[1:0] inode_out[17:2] entries_used[22:18]  | tvalid/tready
//         |     | zero fill bit 23                                 |
//
// One command at a time. An insert goes straight to its result. A search compares entries
// in order up to a hit or the last live entry; a delete that hits then shifts the entries
// above it down by one, so a delete that hits is the longest command. Reads go through the
// single read port of the entry memory (one entry read per cycle, registered read data).
// Reset clears all but the entry memory and read data; the memory needs no clearing.
// s_tready is high only between commands; a finished result waits in the output
// register, and a new command is taken while it waits.
module file_name_directory_table
	import fndt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int NAME_BYTES    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // cmd, name_high, name_low, inode_in
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status, inode_out, entries_used
);

	localparam int IW = $clog2(TABLE_ENTRIES);       // entry index width
	localparam int CW = $clog2(TABLE_ENTRIES + 1);   // count width
	localparam int KW = NAME_BYTES * 8;              // stored name bits
	localparam int EW = KW + INODE_W;                // memory word width

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		SHIFT,
		RESP
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [KW-1:0]       key_q;
	logic                del_q;
	logic [STAT_W-1:0]   resp_status_q;
	logic [INODE_W-1:0]  resp_inode_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	// entry memory: {name key, inode}
	logic [EW-1:0]       mem [TABLE_ENTRIES];
	logic [EW-1:0]       rd_data_q;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [EW-1:0]       mem_wdata;
	logic [CW-1:0]       rd_addr;

	logic [CMD_W-1:0]    cmd_in;
	logic [2*HALF_W-1:0] name_full;
	logic [KW-1:0]       key_in;
	logic [INODE_W-1:0]  inode_in;
	logic                accept;
	logic                full;
	logic                hit;
	logic [CW-1:0]       idx_next;
	logic                more;
	logic                resp_load;

	// input unpack; the name is big-endian, byte 0 on top, keep the first NAME_BYTES
	assign cmd_in    = s_tdata[1:0];
	assign name_full = {s_tdata[65:2], s_tdata[129:66]};
	assign key_in    = name_full[2*HALF_W-1 -: KW];
	assign inode_in  = s_tdata[145:130];

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q >= CW'(TABLE_ENTRIES));
	assign hit      = (rd_data_q[EW-1:INODE_W] == key_q);
	assign idx_next = idx_q + CW'(1);
	assign more     = (idx_next < count_q);

	// result goes into the output register when it is empty or being drained
	assign resp_load = (state_q == RESP) && (!m_tvalid_q || m_tready);

	// read address runs one entry ahead of the compare / move
	always_comb begin
		case (state_q)
			SCAN:    rd_addr = idx_next;
			SHIFT:   rd_addr = idx_q + CW'(2);
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IW-1:0];
		mem_wdata = {key_in, inode_in};
		if (accept && cmd_in == CMD_INSERT && !full) begin
			mem_we = 1'b1;
		end else if (state_q == SHIFT && more) begin
			// close the gap: entry idx+1 moves down to idx
			mem_we    = 1'b1;
			mem_waddr = idx_q[IW-1:0];
			mem_wdata = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			key_q         <= '0;
			del_q         <= 1'b0;
			resp_status_q <= ST_DONE;
			resp_inode_q  <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			if (resp_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						key_q        <= key_in;
						del_q        <= (cmd_in == CMD_DELETE);
						idx_q        <= '0;
						resp_inode_q <= '0;
						state_q      <= RESP;
						case (cmd_in)
							CMD_INSERT: begin
								if (full) begin
									resp_status_q <= ST_FULL;
								end else begin
									resp_status_q <= ST_DONE;
									count_q       <= count_q + CW'(1);
								end
							end
							CMD_SEARCH, CMD_DELETE: begin
								resp_status_q <= ST_NOT_FOUND;
								if (count_q != '0) begin
									state_q <= SCAN;
								end
							end
							default: begin
								resp_status_q <= ST_NOT_FOUND;
							end
						endcase
					end
				end
				SCAN: begin
					if (hit) begin
						resp_status_q <= ST_DONE;
						resp_inode_q  <= rd_data_q[INODE_W-1:0];
						state_q       <= del_q ? SHIFT : RESP;
					end else if (more) begin
						idx_q <= idx_next;
					end else begin
						state_q <= RESP;
					end
				end
				SHIFT: begin
					if (more) begin
						idx_q <= idx_next;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= RESP;
					end
				end
				RESP: begin
					if (resp_load) begin
						m_tdata_q  <= {1'b0, USED_W'(count_q), resp_inode_q, resp_status_q};
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// table never holds more than its capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count above capacity");

	// scan and shift only touch live entries
	a_idx_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN || state_q == SHIFT) |-> (idx_q < count_q))
		else $error("scan index beyond live entries");

	// one command moves the count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (count_q == $past(count_q) ||
		count_q == $past(count_q) + CW'(1) || count_q + CW'(1) == $past(count_q)))
		else $error("entry count jumped");

	// memory writes only on insert or while closing a gap
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (accept || state_q == SHIFT))
		else $error("unexpected entry write");

endmodule
